[rtl/rgb_to_hsi_pixel_assert.svh]
// Assertion macros for the RGB to HSI pixel converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RGB_TO_HSI_PIXEL_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_ASSERT_SVH

// Same-cycle implication
`define RGBHSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RGBHSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rgbhsi_pkg.sv]
// Shared types and constants for the RGB to HSI pixel pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbhsi_pkg;

    localparam int ANG_FRAC     = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_BITS     = 17;
    localparam int VEC_W        = 30;
    localparam int SQRT3_Q16    = 113512;
    localparam int INV6_Q18     = 43691;

    localparam logic signed [VEC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    // Data carried by every pipeline stage
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] ang;
        logic [26:0]             num;
        logic [10:0]             den;
        logic [10:0]             rem;
        logic [DIV_BITS-1:0]     quo;
        logic                    blue_gt;
        logic                    gray;
        logic                    sum_zero;
        logic [9:0]              inten;
    } pipe_t;

endpackage
`default_nettype wire

[rtl/rgbhsi_cordic_stage.sv]
// One pipeline stage: one vectoring CORDIC rotation plus, in the first DIV_BITS
// stages, one restoring division step for saturation. Depends on rgbhsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsi_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             valid_prev,
    input  rgbhsi_pkg::pipe_t     d_prev,
    output logic                  valid_cur,
    output rgbhsi_pkg::pipe_t     d_cur
);
    import rgbhsi_pkg::*;

    pipe_t d_next;
    pipe_t d_reg;
    logic  valid_reg;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;

    // CORDIC rotation toward the x axis
    always_comb
    begin
        d_next = d_prev;
        xs = d_prev.x >>> STEP;
        ys = d_prev.y >>> STEP;
        if (!d_prev.y[VEC_W-1])
        begin
            d_next.x   = d_prev.x + ys;
            d_next.y   = d_prev.y - xs;
            d_next.ang = d_prev.ang + ATAN_TAB[STEP];
        end
        else
        begin
            d_next.x   = d_prev.x - ys;
            d_next.y   = d_prev.y + xs;
            d_next.ang = d_prev.ang - ATAN_TAB[STEP];
        end
    end

    // One quotient bit per stage in the first DIV_BITS stages, MSB first
    pipe_t d_div;
    generate
        if (STEP < DIV_BITS)
        begin : g_div
            localparam int K = DIV_BITS - 1 - STEP;
            logic [11:0] trial;
            always_comb
            begin
                d_div = d_next;
                trial = {d_prev.rem, d_prev.num[K]};
                if (trial >= {1'b0, d_prev.den})
                begin
                    d_div.rem    = 11'(trial - {1'b0, d_prev.den});
                    d_div.quo[K] = 1'b1;
                end
                else
                begin
                    d_div.rem = trial[10:0];
                end
            end
        end
        else
        begin : g_nodiv
            always_comb
            begin
                d_div = d_next;
            end
        end
    endgenerate

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_prev;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_div;
    end

    assign valid_cur = valid_reg;
    assign d_cur     = d_reg;

endmodule
`default_nettype wire

[rtl/rgb_to_hsi_pixel.sv]
// RGB to HSI pixel converter, top level: front stage, CORDIC chain, output stage.
// Depends on rgbhsi_pkg, rgbhsi_cordic_stage and rgb_to_hsi_pixel_assert.svh.
// Path from pixel transaction to result: front register, 24 CORDIC stages,
// output register. Throughput: one pixel per cycle while hsi_ready does not stall.
// A stage loads whenever it is empty or the next stage loads, so bubbles
// are squeezed out under back pressure. Reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsi_pixel #(
    parameter int HUE_FRAC_BITS = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_ready,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             hsi_valid,
    input  wire logic        hsi_ready,
    output logic [15:0]      hue,
    output logic [16:0]      saturation,
    output logic [9:0]       intensity,
    output logic             achromatic
);
    import rgbhsi_pkg::*;

    localparam int RND_SH = ANG_FRAC - HUE_FRAC_BITS;
    localparam logic signed [31:0] HUE_LIM  = 32'sd360 <<< HUE_FRAC_BITS;
    localparam logic signed [31:0] RND_HALF = 32'sd1 <<< (RND_SH - 1);
    localparam logic signed [31:0] ANG_180  = 32'sd180 <<< ANG_FRAC;
    localparam logic signed [31:0] ANG_360  = 32'sd360 <<< ANG_FRAC;

    // Front stage: differences, pre-rotation, min, sum, intensity
    pipe_t front_next;
    pipe_t front_reg;
    logic  front_vld_reg;
    logic  front_en;
    logic signed [10:0] dx;
    logic signed [9:0]  dgb;
    logic [7:0]         dgb_abs;
    logic signed [VEC_W-1:0] x0;
    logic signed [VEC_W-1:0] y0;
    logic [7:0]  mn;
    logic [9:0]  sum;
    logic [9:0]  diff;
    logic [12:0] n6;
    logic [28:0] prod6;

    always_comb
    begin
        dx      = 11'(signed'({3'b0, red}) * 2) - 11'(signed'({3'b0, green}))
                  - 11'(signed'({3'b0, blue}));
        dgb     = signed'({2'b0, green}) - signed'({2'b0, blue});
        dgb_abs = dgb[9] ? 8'(-dgb) : dgb[7:0];
        x0      = VEC_W'(dx) <<< 16;
        y0      = signed'(VEC_W'({22'b0, dgb_abs} * 30'(SQRT3_Q16)));
        mn      = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        sum     = 10'({2'b0, red} + {2'b0, green} + {2'b0, blue});
        diff    = 10'(sum - 10'({2'b0, mn} * 3));
        n6      = 13'({sum, 3'b0} + 13'd3);
        prod6   = 29'({16'b0, n6} * 29'(INV6_Q18));

        front_next          = '0;
        front_next.blue_gt  = blue > green;
        front_next.gray     = (red == green) && (green == blue);
        front_next.sum_zero = (sum == 10'd0);
        front_next.num      = {diff, 17'b0} | {17'b0, sum};
        front_next.den      = {sum, 1'b0};
        front_next.rem      = {1'b0, diff};
        front_next.quo      = '0;
        front_next.inten    = prod6[27:18];
        if (x0 < 0)
        begin
            front_next.x   = y0;
            front_next.y   = -x0;
            front_next.ang = VEC_W'(32'sd90 <<< ANG_FRAC);
        end
        else
        begin
            front_next.x   = x0;
            front_next.y   = y0;
            front_next.ang = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= 1'b0;
        else if (front_en)
            front_vld_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
            front_reg <= front_next;
    end

    // CORDIC chain
    logic  stg_vld [CORDIC_STEPS+1];
    pipe_t stg_dat [CORDIC_STEPS+1];
    logic  stg_en  [CORDIC_STEPS+1];
    logic  out_en;

    assign stg_vld[0] = front_vld_reg;
    assign stg_dat[0] = front_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_stage
            assign stg_en[gi] = !stg_vld[gi+1] || stg_en[gi+1];
            rgbhsi_cordic_stage #(
                .STEP (gi)
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (stg_en[gi]),
                .valid_prev (stg_vld[gi]),
                .d_prev     (stg_dat[gi]),
                .valid_cur  (stg_vld[gi+1]),
                .d_cur      (stg_dat[gi+1])
            );
        end
    endgenerate

    assign stg_en[CORDIC_STEPS] = out_en;
    assign front_en  = !front_vld_reg || stg_en[0];
    assign pix_ready = front_en;

    // Output stage: clamp, reflect, round hue; finish saturation
    pipe_t fin;
    logic signed [31:0] h;
    logic [15:0] hue_next;
    logic [16:0] sat_next;
    logic        vld_out_reg;
    logic [15:0] hue_reg;
    logic [16:0] sat_reg;
    logic [9:0]  int_reg;
    logic        achr_reg;

    always_comb
    begin
        fin = stg_dat[CORDIC_STEPS];
        h   = 32'(fin.ang);
        if (h < 0)       h = '0;
        if (h > ANG_180) h = ANG_180;
        if (fin.blue_gt) h = ANG_360 - h;
        h = (h + RND_HALF) >>> RND_SH;
        if (h > HUE_LIM) h = HUE_LIM;
        hue_next = fin.gray ? 16'd0 : h[15:0];
        sat_next = fin.sum_zero ? 17'd0 : fin.quo;
    end

    assign out_en = !vld_out_reg || hsi_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (out_en)
            vld_out_reg <= stg_vld[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            int_reg  <= fin.inten;
            achr_reg <= fin.gray;
        end
    end

    assign hsi_valid  = vld_out_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign intensity  = int_reg;
    assign achromatic = achr_reg;

`include "rgb_to_hsi_pixel_assert.svh"

    `RGBHSI_ASSERT_NOW(a_gray_hue, hsi_valid && achromatic, hue == 16'd0, "gray pixel with hue")
    `RGBHSI_ASSERT_NOW(a_int_range, hsi_valid, intensity <= 10'd1020, "intensity out of range")
    `RGBHSI_ASSERT_NOW(a_sat_range, hsi_valid, saturation <= 17'd65536, "saturation out of range")
    `RGBHSI_ASSERT_NEXT(a_hold, hsi_valid && !hsi_ready, hsi_valid, "result dropped under stall")

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking bench for the RGB to HSI pixel converter (rgb_to_hsi_pixel).
// Drives pixels through valid/ready with random gaps and stalls, predicts HSI
// with an integer CORDIC model and compares each result transaction in order.
`timescale 1ns / 1ps
module testbench;

    localparam int HUE_FRAC  = 7;
    localparam int ANGF      = 20;
    localparam int STEPS     = 24;
    localparam int LATENCY   = 26;
    localparam int MAX_CYC   = 400000;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] sat;
        logic [9:0]  inten;
        logic        achrom;
    } hsi_t;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        hsi_valid;
    logic        hsi_ready;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [9:0]  intensity;
    logic        achromatic;

    pixel_t pixel_q[$];
    hsi_t   hsi_expected_q[$];
    int     mismatch_cnt;
    int     cycle_cnt;
    bit     hold_sender;
    bit     stim_done;

    rgb_to_hsi_pixel #(.HUE_FRAC_BITS(HUE_FRAC)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsi_valid  (hsi_valid),
        .hsi_ready  (hsi_ready),
        .hue        (hue),
        .saturation (saturation),
        .intensity  (intensity),
        .achromatic (achromatic)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Floor shift for signed 64-bit values
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // Arctangent table in 2^-20 degree
    function automatic longint atan_deg(int i);
        longint t[STEPS];
        t = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
              469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
              917, 458, 229, 115, 57, 29, 14, 7};
        return t[i];
    endfunction

    // Expected HSI of one pixel
    function automatic hsi_t rgb_to_hsi(pixel_t p);
        longint r, g, b, sum, mn, x, y, xs, ys, ang, tmp, h;
        hsi_t   o;
        r = p.r;
        g = p.g;
        b = p.b;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        o.achrom = (r == g) && (g == b);
        o.hue = '0;
        if (!o.achrom)
        begin
            x = (2 * r - g - b) * 65536;
            y = ((g > b) ? g - b : b - g) * 113512;
            ang = 0;
            if (x < 0)
            begin
                tmp = x;
                x = y;
                y = -tmp;
                ang = longint'(90) << ANGF;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    ang += atan_deg(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    ang -= atan_deg(i);
                end
            end
            if (ang < 0) ang = 0;
            if (ang > (longint'(180) << ANGF)) ang = longint'(180) << ANGF;
            if (b > g) ang = (longint'(360) << ANGF) - ang;
            h = (ang + (longint'(1) << (ANGF - HUE_FRAC - 1))) >>> (ANGF - HUE_FRAC);
            if (h > (longint'(360) << HUE_FRAC)) h = longint'(360) << HUE_FRAC;
            o.hue = h[15:0];
        end
        o.sat = (sum > 0) ? 17'(((sum - 3 * mn) * 131072 + sum) / (2 * sum)) : '0;
        o.inten = 10'((8 * sum + 3) / 6);
        return o;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Stimulus: directed corners, then random pixels in bursts
    initial
    begin
        pixel_t p;
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd128, 8'd128, 8'd128});
        pixel_q.push_back('{8'd255, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd0});
        pixel_q.push_back('{8'd0, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd0, 8'd255});
        pixel_q.push_back('{8'd1, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd1});
        pixel_q.push_back('{8'd0, 8'd1, 8'd0});
        pixel_q.push_back('{8'd255, 8'd254, 8'd255});
        pixel_q.push_back('{8'd254, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd254});
        pixel_q.push_back('{8'd0, 8'd128, 8'd129});
        pixel_q.push_back('{8'd0, 8'd129, 8'd128});
        pixel_q.push_back('{8'd100, 8'd50, 8'd50});
        pixel_q.push_back('{8'd50, 8'd100, 8'd100});
        pixel_q.push_back('{8'd170, 8'd85, 8'd0});
        for (int n = 0; n < 1800; n++)
        begin
            case ($urandom_range(0, 9))
                0:       p = '{8'($urandom), 8'($urandom), 8'($urandom)};
                1:
                begin
                    p.r = 8'($urandom);
                    p.g = p.r;
                    p.b = p.r;
                end
                2:
                begin
                    p.r = 8'($urandom);
                    p.g = p.r;
                    p.b = 8'($urandom);
                end
                3:
                begin
                    p.g = 8'($urandom);
                    p.b = 8'(p.g + $urandom_range(0, 2) - 1);
                    p.r = 8'($urandom);
                end
                default: p = pixel_t'(24'($urandom));
            endcase
            pixel_q.push_back(p);
        end
    end

    // Driver: pulls from the pending queue, holds payload until accepted
    int  send_gap;
    int  sent_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid   <= 1'b0;
            red         <= '0;
            green       <= '0;
            blue        <= '0;
            send_gap    <= 0;
            sent_cnt    <= 0;
            hold_sender <= 1'b0;
            stim_done   <= 1'b0;
        end
        else if (!pix_valid || pix_ready)
        begin
            if (pix_valid)
                sent_cnt <= sent_cnt + 1;
            // One drain pause midway through the run
            if (pix_valid && sent_cnt == 900)
            begin
                hold_sender <= 1'b1;
                pix_valid   <= 1'b0;
            end
            else if (hold_sender)
            begin
                if (hsi_expected_q.size() == 0)
                    hold_sender <= 1'b0;
                pix_valid <= 1'b0;
            end
            else if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                pix_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel_t p;
                p = pixel_q.pop_front();
                pix_valid <= 1'b1;
                red       <= p.r;
                green     <= p.g;
                blue      <= p.b;
                send_gap  <= gap_len();
            end
            else
            begin
                pix_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Record expectation for every accepted pixel transaction
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
            hsi_expected_q.push_back(rgb_to_hsi('{red, green, blue}));
    end

    // Monitor: random back pressure and in-order compare
    int stall_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsi_ready    <= 1'b0;
            stall_cnt    <= 0;
            mismatch_cnt <= 0;
        end
        else
        begin
            if (hsi_valid && hsi_ready)
            begin
                if (hsi_expected_q.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("Unexpected result transaction: hue=%0d sat=%0d int=%0d ach=%0d",
                                 hue, saturation, intensity, achromatic);
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                else
                begin
                    hsi_t e;
                    e = hsi_expected_q.pop_front();
                    if (e.hue !== hue || e.sat !== saturation || e.inten !== intensity
                        || e.achrom !== achromatic)
                    begin
                        if (mismatch_cnt < 10)
                            $display("Result mismatch: exp hue=%0d sat=%0d int=%0d ach=%0d, got hue=%0d sat=%0d int=%0d ach=%0d",
                                     e.hue, e.sat, e.inten, e.achrom,
                                     hue, saturation, intensity, achromatic);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                hsi_ready <= 1'b0;
            end
            else
            begin
                stall_cnt <= gap_len();
                hsi_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // Reset, completion wait and verdict
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && hsi_expected_q.size() == 0))
            @(posedge clk);
        repeat (LATENCY + 50) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        wait (cycle_cnt >= MAX_CYC);
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
